>>> rtl/tws_pkg.sv
// Shared types, constants and codes for the temperature window statistics monitor.
// No dependencies; compiled first.
`default_nettype none

package tws_pkg;

    localparam int WINDOW_DEPTH_DEF = 100;
    localparam int SAMPLE_WIDTH_DEF = 13;

    localparam int READING_W   = 12;
    localparam int CAL_W       = READING_W + 1;
    localparam int OFFSET_W    = 12;
    localparam int MULT_W      = 6;
    localparam int THRESH_W    = 12;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 12;

    localparam logic [CFG_INDEX_W-1:0] REG_CAL_OFFSET   = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_ANOMALY_MULT = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] REG_RATE_THRESH  = CFG_INDEX_W'(2);

    localparam logic [MULT_W-1:0]   MULT_RESET   = MULT_W'(8);
    localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(8);

    localparam int LOW_LIMIT  = -880;
    localparam int HIGH_LIMIT = 2000;
    localparam int RATE_SPAN  = 5;
    localparam int FIT_SPAN   = 20;
    localparam int FIT_SUM_X  = FIT_SPAN * (FIT_SPAN - 1) / 2;

    // reciprocals: divide by RATE_SPAN and by 1330 with a multiply and a shift
    localparam int          RATE_RECIP_SHIFT = 22;
    localparam logic [19:0] RATE_RECIP       = 20'd838861;
    localparam int          FIT_RECIP_SHIFT  = 34;
    localparam logic [23:0] FIT_RECIP        = 24'd12917195;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PASS,
        S_PREP,
        S_MUL_GO,
        S_MUL_WAIT,
        S_DIV_GO,
        S_DIV_WAIT,
        S_OUT
    } state_t;

    typedef enum logic [2:0] {
        OP_NS2,
        OP_S1SQ,
        OP_DEVSQ,
        OP_MD,
        OP_VAR,
        OP_MEAN
    } op_t;

    typedef struct packed {
        logic accept;
        logic pass_issue;
        logic prep;
        logic mul_start;
        logic div_start;
        logic capture;
        logic load_out;
        op_t  op;
    } cmd_t;

    typedef struct packed {
        logic issue_done;
        logic mul_idle;
        logic div_idle;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

>>> rtl/tws_if.sv
// Channel interfaces: reading input and statistics result output.
// Depends on tws_pkg.
`default_nettype none

interface tws_in_if;
    import tws_pkg::*;
    logic                        valid;
    logic                        ready;
    logic signed [READING_W-1:0] reading;

    modport source (output valid, output reading, input ready);
    modport sink (input valid, input reading, output ready);
endinterface

interface tws_out_if #(
    parameter int SAMPLE_WIDTH = tws_pkg::SAMPLE_WIDTH_DEF,
    parameter int WINDOW_DEPTH = tws_pkg::WINDOW_DEPTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic                           status;
    logic signed [SAMPLE_WIDTH-1:0] current;
    logic signed [SAMPLE_WIDTH-1:0] mean;
    logic signed [SAMPLE_WIDTH-1:0] minimum;
    logic signed [SAMPLE_WIDTH-1:0] maximum;
    logic [2*SAMPLE_WIDTH-2:0]      variance;
    logic signed [SAMPLE_WIDTH:0]   rate_of_change;
    logic signed [SAMPLE_WIDTH+1:0] predicted;
    logic                           anomaly;
    logic [$clog2(WINDOW_DEPTH+1)-1:0] sample_count;

    modport source (output valid, output status, output current, output mean,
                    output minimum, output maximum, output variance,
                    output rate_of_change, output predicted, output anomaly,
                    output sample_count, input ready);
    modport sink (input valid, input status, input current, input mean,
                  input minimum, input maximum, input variance,
                  input rate_of_change, input predicted, input anomaly,
                  input sample_count, output ready);
endinterface

`default_nettype wire

>>> rtl/tws_ctrl.sv
// Sequencer: accept, sample pass, multiply and divide steps, result hand-off.
// Depends on tws_pkg.
`default_nettype none

module tws_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 ready,
    input  wire tws_pkg::status_t status,
    output tws_pkg::cmd_t        cmd
);
    import tws_pkg::*;

    state_t state_reg, state_next;
    op_t    op_reg, op_next;

    function automatic op_t next_op(input op_t op);
        op_t r;
        unique case (op)
            OP_NS2:   r = OP_S1SQ;
            OP_S1SQ:  r = OP_DEVSQ;
            OP_DEVSQ: r = OP_MD;
            OP_MD:    r = OP_VAR;
            OP_VAR:   r = OP_MEAN;
            OP_MEAN:  r = OP_NS2;
            default:  r = OP_NS2;
        endcase
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= OP_NS2;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_PASS;
            end
            S_PASS:
            begin
                if (status.issue_done)
                    state_next = S_PREP;
            end
            S_PREP:
            begin
                state_next = S_MUL_GO;
                op_next    = OP_NS2;
            end
            S_MUL_GO:
                state_next = S_MUL_WAIT;
            S_MUL_WAIT:
            begin
                if (status.mul_idle)
                begin
                    op_next    = next_op(op_reg);
                    state_next = (op_reg == OP_MD) ? S_DIV_GO : S_MUL_GO;
                end
            end
            S_DIV_GO:
                state_next = S_DIV_WAIT;
            S_DIV_WAIT:
            begin
                if (status.div_idle)
                begin
                    op_next    = next_op(op_reg);
                    state_next = (op_reg == OP_MEAN) ? S_OUT : S_DIV_GO;
                end
            end
            S_OUT:
            begin
                if (status.out_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        ready          = (state_reg == S_IDLE);
        cmd.accept     = (state_reg == S_IDLE) && in_valid;
        cmd.pass_issue = (state_reg == S_PASS);
        cmd.prep       = (state_reg == S_PREP);
        cmd.mul_start  = (state_reg == S_MUL_GO);
        cmd.div_start  = (state_reg == S_DIV_GO);
        cmd.capture    = ((state_reg == S_MUL_WAIT) && status.mul_idle)
                      || ((state_reg == S_DIV_WAIT) && status.div_idle);
        cmd.load_out   = (state_reg == S_OUT) && status.out_free;
        cmd.op         = op_reg;
    end

endmodule

`default_nettype wire

>>> rtl/tws_datapath.sv
// Datapath: sample ring, configuration registers, accumulators, shift-add
// multiplier, restoring divider and result register. Depends on tws_pkg, tws_if.
`default_nettype none

module tws_datapath #(
    parameter int WINDOW_DEPTH = tws_pkg::WINDOW_DEPTH_DEF,
    parameter int SAMPLE_WIDTH = tws_pkg::SAMPLE_WIDTH_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic signed [tws_pkg::READING_W-1:0] reading,
    input  wire logic                                wr_en,
    input  wire logic [tws_pkg::CFG_INDEX_W-1:0]     wr_index,
    input  wire logic [tws_pkg::CFG_DATA_W-1:0]      wr_data,
    input  wire tws_pkg::cmd_t                       cmd,
    output tws_pkg::status_t                         status,
    tws_out_if.source                                results
);
    import tws_pkg::*;

    localparam int W      = WINDOW_DEPTH;
    localparam int SW     = SAMPLE_WIDTH;
    localparam int IDX_W  = $clog2(W);
    localparam int CNT_W  = $clog2(W + 1);
    localparam int S1_W   = SW + CNT_W;
    localparam int S2_W   = 2 * SW + CNT_W;
    localparam int A5_W   = SW + 3;
    localparam int SY_W   = SW + 5;
    localparam int SXY_W  = SW + 9;
    localparam int DEV_W  = SW + CNT_W + 2;
    localparam int MB     = SW + CNT_W + 1;
    localparam int PW     = 2 * SW + 2 * CNT_W + 12;
    localparam int DVW    = 2 * SW + 2 * CNT_W;
    localparam int DSW    = 2 * CNT_W + 1;
    localparam int D_W    = SW + 4;
    localparam int NUM_W  = SW + 14;
    localparam int VAR_W  = 2 * SW - 1;
    localparam int RATE_W = SW + 1;
    localparam int PRED_W = SW + 2;
    localparam int TERM_W = SW + 4;
    localparam int PF_W   = SW + 5;
    localparam int RQ_W   = D_W + 20;
    localparam int TQ_W   = NUM_W + 24;
    localparam int MC_W   = $clog2(MB + 1);
    localparam int DC_W   = $clog2(DVW + 1);
    localparam logic signed [PF_W-1:0] P_MAX = PF_W'((1 << (PRED_W - 1)) - 1);
    localparam logic signed [PF_W-1:0] P_MIN = -PF_W'(1 << (PRED_W - 1));

    // configuration
    logic signed [OFFSET_W-1:0] offset_reg;
    logic [MULT_W-1:0]          mult_reg;
    logic [THRESH_W-1:0]        thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
            mult_reg   <= MULT_RESET;
            thr_reg    <= THRESH_RESET;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_CAL_OFFSET:   offset_reg <= $signed(wr_data[OFFSET_W-1:0]);
                REG_ANOMALY_MULT: mult_reg   <= wr_data[MULT_W-1:0];
                REG_RATE_THRESH:  thr_reg    <= wr_data[THRESH_W-1:0];
                default:          ;
            endcase
        end
    end

    // ring and pointers
    logic signed [SW-1:0] ring_reg [W];
    logic signed [SW-1:0] rd_data_reg;
    logic [IDX_W-1:0]     wp_reg, rp_reg, wp_dec;
    logic [CNT_W-1:0]     fill_reg, k_reg, k_d_reg;
    logic signed [SW-1:0] last_reg;
    logic                 acc_v_reg;
    logic                 status_reg;
    logic                 range_ok, ram_we, rd_en;
    logic signed [CAL_W-1:0] cal_sum;
    logic signed [SW-1:0]    cal_value;

    assign range_ok  = (reading > LOW_LIMIT) && (reading < HIGH_LIMIT);
    assign cal_sum   = CAL_W'(reading) + CAL_W'(offset_reg);
    assign cal_value = SW'(cal_sum);
    assign ram_we    = cmd.accept && range_ok;
    assign rd_en     = cmd.pass_issue && (k_reg != fill_reg);
    assign wp_dec    = (wp_reg == '0) ? IDX_W'(W - 1) : wp_reg - 1'b1;

    always_ff @(posedge clk)
    begin
        if (ram_we)
            ring_reg[wp_reg] <= cal_value;
        if (rd_en)
            rd_data_reg <= ring_reg[rp_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg     <= '0;
            fill_reg   <= '0;
            last_reg   <= '0;
            k_reg      <= '0;
            rp_reg     <= '0;
            acc_v_reg  <= 1'b0;
            status_reg <= 1'b0;
        end
        else
        begin
            acc_v_reg <= rd_en;
            if (cmd.accept)
            begin
                status_reg <= !range_ok;
                k_reg      <= '0;
                rp_reg     <= range_ok ? wp_reg : wp_dec;
                if (range_ok)
                begin
                    wp_reg   <= (wp_reg == IDX_W'(W - 1)) ? '0 : wp_reg + 1'b1;
                    last_reg <= cal_value;
                    if (fill_reg < CNT_W'(W))
                        fill_reg <= fill_reg + 1'b1;
                end
            end
            else if (rd_en)
            begin
                k_reg  <= k_reg + 1'b1;
                rp_reg <= (rp_reg == '0) ? IDX_W'(W - 1) : rp_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            k_d_reg <= k_reg;
    end

    // accumulate, newest sample first
    logic signed [S1_W-1:0]  s1_reg;
    logic [S2_W-1:0]         s2_reg;
    logic signed [SW-1:0]    min_reg, max_reg;
    logic signed [A5_W-1:0]  a5_reg, b5_reg;
    logic signed [SY_W-1:0]  sy_reg;
    logic signed [SXY_W-1:0] sxy_reg;
    logic signed [2*SW-1:0]  sq;
    logic [4:0]              coef;
    logic signed [SXY_W-1:0] wxy;

    assign sq   = rd_data_reg * rd_data_reg;
    assign coef = 5'(FIT_SPAN - 1) - k_d_reg[4:0];
    assign wxy  = SXY_W'($signed({1'b0, coef})) * SXY_W'(rd_data_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            s1_reg  <= '0;
            s2_reg  <= '0;
            a5_reg  <= '0;
            b5_reg  <= '0;
            sy_reg  <= '0;
            sxy_reg <= '0;
        end
        else if (acc_v_reg)
        begin
            s1_reg <= s1_reg + S1_W'(rd_data_reg);
            s2_reg <= s2_reg + S2_W'($unsigned(sq));
            if (k_d_reg == '0)
            begin
                min_reg <= rd_data_reg;
                max_reg <= rd_data_reg;
            end
            else
            begin
                if (rd_data_reg < min_reg)
                    min_reg <= rd_data_reg;
                if (rd_data_reg > max_reg)
                    max_reg <= rd_data_reg;
            end
            if (k_d_reg < RATE_SPAN)
                a5_reg <= a5_reg + A5_W'(rd_data_reg);
            else if (k_d_reg < 2 * RATE_SPAN)
                b5_reg <= b5_reg + A5_W'(rd_data_reg);
            if (k_d_reg < FIT_SPAN)
            begin
                sy_reg  <= sy_reg + SY_W'(rd_data_reg);
                sxy_reg <= sxy_reg + wxy;
            end
        end
    end

    // derived terms
    logic [2*CNT_W-1:0]      nn_reg, nn;
    logic signed [DEV_W-1:0] nc, dev, dev_abs;
    logic signed [D_W-1:0]   d, d_abs;
    logic signed [NUM_W-1:0] num, num_abs;
    logic signed [S1_W-1:0]  s1_abs;
    logic [S1_W-1:0]         abs_s1_reg;
    logic [MB-1:0]           abs_dev_reg;
    logic [D_W-1:0]          abs_d_reg;
    logic [NUM_W-1:0]        abs_num_reg;
    logic                    s1_neg_reg, d_neg_reg, num_neg_reg;

    assign nn      = fill_reg * fill_reg;
    assign nc      = DEV_W'($signed({1'b0, fill_reg})) * DEV_W'(last_reg);
    assign dev     = nc - DEV_W'(s1_reg);
    assign dev_abs = dev[DEV_W-1] ? -dev : dev;
    assign d       = D_W'(a5_reg) - D_W'(b5_reg);
    assign d_abs   = d[D_W-1] ? -d : d;
    assign num     = NUM_W'(sxy_reg) * NUM_W'(FIT_SPAN) - NUM_W'(sy_reg) * NUM_W'(FIT_SUM_X);
    assign num_abs = num[NUM_W-1] ? -num : num;
    assign s1_abs  = s1_reg[S1_W-1] ? -s1_reg : s1_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            nn_reg      <= nn;
            abs_s1_reg  <= $unsigned(s1_abs);
            s1_neg_reg  <= s1_reg[S1_W-1];
            abs_dev_reg <= $unsigned(dev_abs[MB-1:0]);
            abs_d_reg   <= $unsigned(d_abs);
            d_neg_reg   <= d[D_W-1];
            abs_num_reg <= $unsigned(num_abs);
            num_neg_reg <= num[NUM_W-1];
        end
    end

    // shift-add multiplier
    logic [PW-1:0]       mul_a_reg, mul_p_reg, mul_a_init, dvar_reg, p1_reg, lhs_reg;
    logic [MB-1:0]       mul_b_reg, mul_b_init;
    logic [MC_W-1:0]     mul_cnt_reg;
    logic [2*MULT_W-1:0] mm;
    logic                dev_flag_reg;

    assign mm = mult_reg * mult_reg;

    always_comb
    begin
        unique case (cmd.op)
            OP_NS2:
            begin
                mul_a_init = PW'(s2_reg);
                mul_b_init = MB'(fill_reg);
            end
            OP_S1SQ:
            begin
                mul_a_init = PW'(abs_s1_reg);
                mul_b_init = MB'(abs_s1_reg);
            end
            OP_DEVSQ:
            begin
                mul_a_init = PW'(abs_dev_reg);
                mul_b_init = abs_dev_reg;
            end
            default:
            begin
                mul_a_init = dvar_reg;
                mul_b_init = MB'(mm);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mul_cnt_reg <= '0;
        else if (cmd.mul_start)
            mul_cnt_reg <= MC_W'(MB);
        else if (mul_cnt_reg != '0)
            mul_cnt_reg <= mul_cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_start)
        begin
            mul_a_reg <= mul_a_init;
            mul_b_reg <= mul_b_init;
            mul_p_reg <= '0;
        end
        else if (mul_cnt_reg != '0)
        begin
            if (mul_b_reg[0])
                mul_p_reg <= mul_p_reg + mul_a_reg;
            mul_a_reg <= mul_a_reg << 1;
            mul_b_reg <= mul_b_reg >> 1;
        end
    end

    // restoring divider
    logic [DVW-1:0]  div_q_reg, div_q_init;
    logic [DSW-1:0]  div_rem_reg, div_den_reg, div_den_init;
    logic [DC_W-1:0] div_cnt_reg;
    logic [DSW:0]    div_t;

    assign div_t = {div_rem_reg, div_q_reg[DVW-1]};

    always_comb
    begin
        unique case (cmd.op)
            OP_VAR:
            begin
                div_q_init   = dvar_reg[DVW-1:0];
                div_den_init = DSW'(nn_reg);
            end
            default:
            begin
                div_q_init   = DVW'(abs_s1_reg);
                div_den_init = DSW'(fill_reg);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div_cnt_reg <= '0;
        else if (cmd.div_start)
            div_cnt_reg <= DC_W'(DVW);
        else if (div_cnt_reg != '0)
            div_cnt_reg <= div_cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            div_q_reg   <= div_q_init;
            div_den_reg <= div_den_init;
            div_rem_reg <= '0;
        end
        else if (div_cnt_reg != '0)
        begin
            if (div_t >= {1'b0, div_den_reg})
            begin
                div_rem_reg <= DSW'(div_t - {1'b0, div_den_reg});
                div_q_reg   <= {div_q_reg[DVW-2:0], 1'b1};
            end
            else
            begin
                div_rem_reg <= div_t[DSW-1:0];
                div_q_reg   <= {div_q_reg[DVW-2:0], 1'b0};
            end
        end
    end

    // constant divisions by reciprocal multiplication
    logic [RQ_W-1:0] rate_prod;
    logic [TQ_W-1:0] term_prod;

    assign rate_prod = RQ_W'(abs_d_reg) * RQ_W'(RATE_RECIP);
    assign term_prod = TQ_W'(abs_num_reg) * TQ_W'(FIT_RECIP);

    // capture step results
    logic [VAR_W-1:0]         var_reg;
    logic signed [SW-1:0]     mean_reg;
    logic signed [RATE_W-1:0] rate_reg;
    logic signed [TERM_W-1:0] term_reg;
    logic [SW-1:0]            mean_mag;
    logic [RATE_W-1:0]        rate_mag;
    logic [TERM_W-1:0]        term_mag;

    assign mean_mag = div_q_reg[SW-1:0];
    assign rate_mag = rate_prod[RATE_RECIP_SHIFT +: RATE_W];
    assign term_mag = term_prod[FIT_RECIP_SHIFT +: TERM_W];

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            unique case (cmd.op)
                OP_NS2:
                begin
                    p1_reg   <= mul_p_reg;
                    rate_reg <= $signed(d_neg_reg ? -rate_mag : rate_mag);
                    term_reg <= $signed(num_neg_reg ? -term_mag : term_mag);
                end
                OP_S1SQ:  dvar_reg     <= p1_reg - mul_p_reg;
                OP_DEVSQ: lhs_reg      <= {mul_p_reg[PW-5:0], 4'b0000};
                OP_MD:    dev_flag_reg <= (lhs_reg > mul_p_reg);
                OP_VAR:   var_reg      <= div_q_reg[VAR_W-1:0];
                OP_MEAN:  mean_reg     <= $signed(s1_neg_reg ? -mean_mag : mean_mag);
                default:  ;
            endcase
        end
    end

    // result register
    logic                     out_valid_reg;
    logic [D_W-1:0]           thr_ext, thr5;
    logic signed [PF_W-1:0]   pfull;
    logic signed [PRED_W-1:0] pred_sat;
    logic                     has_any, has_rate, has_fit;

    assign has_any  = (fill_reg != '0);
    assign has_rate = (fill_reg >= 2 * RATE_SPAN);
    assign has_fit  = (fill_reg >= FIT_SPAN);
    assign thr_ext  = D_W'(thr_reg);
    assign thr5     = (thr_ext << 2) + thr_ext;
    assign pfull    = PF_W'(last_reg) + PF_W'(term_reg);

    always_comb
    begin
        priority if (pfull > P_MAX)
            pred_sat = PRED_W'(P_MAX);
        else if (pfull < P_MIN)
            pred_sat = PRED_W'(P_MIN);
        else
            pred_sat = PRED_W'(pfull);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_out)
            out_valid_reg <= 1'b1;
        else if (results.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            results.status         <= status_reg;
            results.current        <= last_reg;
            results.mean           <= has_any ? mean_reg : '0;
            results.minimum        <= has_any ? min_reg : '0;
            results.maximum        <= has_any ? max_reg : '0;
            results.variance       <= has_any ? var_reg : '0;
            results.rate_of_change <= has_rate ? rate_reg : '0;
            results.predicted      <= has_fit ? pred_sat : PRED_W'(last_reg);
            results.anomaly        <= (has_any && dev_flag_reg)
                                   || (has_rate && (abs_d_reg > thr5));
            results.sample_count   <= fill_reg;
        end
    end

    assign results.valid     = out_valid_reg;
    assign status.issue_done = (k_reg == fill_reg);
    assign status.mul_idle   = (mul_cnt_reg == '0);
    assign status.div_idle   = (div_cnt_reg == '0);
    assign status.out_free   = !out_valid_reg || results.ready;

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(W))
        else $error("fill count beyond window depth");
    a_reject_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && !range_ok) |=> ($stable(wp_reg) && $stable(fill_reg)))
        else $error("rejected reading changed the ring state");
    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> results.valid)
        else $error("result beat not presented after load");
    a_mul_done: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.capture && (cmd.op == OP_NS2 || cmd.op == OP_S1SQ
                         || cmd.op == OP_DEVSQ || cmd.op == OP_MD))
        |-> (mul_cnt_reg == '0))
        else $error("product captured before multiplier finished");
`endif

endmodule

`default_nettype wire

>>> rtl/temperature_window_stats_monitor.sv
// Top level of the temperature window statistics monitor.
// Depends on tws_pkg, tws_if, tws_ctrl, tws_datapath.
//
// One reading beat is taken at a time. Each beat makes a pass over the stored samples in
// the sample ring (one memory read per cycle), then four products in a one-bit-per-cycle
// shift-add multiplier and two quotients (variance and mean) in a one-bit-per-cycle
// restoring divider; the rate and the prediction term divide by constants through
// reciprocal multiplication. The result beat waits in an output register, so the next
// reading is taken while it is still unclaimed.
`default_nettype none

module temperature_window_stats_monitor #(
    parameter int WINDOW_DEPTH = tws_pkg::WINDOW_DEPTH_DEF,
    parameter int SAMPLE_WIDTH = tws_pkg::SAMPLE_WIDTH_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    tws_in_if.sink                               readings,
    tws_out_if.source                            results,
    input  wire logic                            wr_en,
    input  wire logic [tws_pkg::CFG_INDEX_W-1:0] wr_index,
    input  wire logic [tws_pkg::CFG_DATA_W-1:0]  wr_data
);
    import tws_pkg::*;

    cmd_t    cmd;
    status_t status;
    logic    ready;

    assign readings.ready = ready;

    tws_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (readings.valid),
        .ready    (ready),
        .status   (status),
        .cmd      (cmd)
    );

    tws_datapath #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .reading  (readings.reading),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cmd      (cmd),
        .status   (status),
        .results  (results)
    );

endmodule

`default_nettype wire
